// ----- design/bb3_pkg.sv -----
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel and window types, counter widths and register indexes.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int EW_W       = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int IR_W       = FH_W + 1;
    localparam int CFG_DATA_W = 16;
    localparam int CSUM_W     = 10;
    localparam int SUM_W      = 12;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [COL_W-1:0] col_addr_t;

    // Red in the lowest byte, as on the stream.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t bot;
        pixel_t mid;
        pixel_t top;
    } win_col_t;

    typedef struct packed {
        pixel_t mid;
        pixel_t up;
    } line_pair_t;

    typedef struct packed {
        logic [CSUM_W-1:0] blue;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] red;
    } chan_sum_t;

    typedef struct packed {
        logic use_col;
        logic use_top;
        logic use_bot;
    } cell_mask_t;

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } win_mask_t;

    typedef enum logic [1:0] {
        DIV_NINE = 2'd0,
        DIV_SIX  = 2'd1,
        DIV_FOUR = 2'd2
    } div_kind_t;

endpackage

// ----- design/box_blur_3x3_edge_clipped_core.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_core: 3x3 box blur with edge clipping
// Averages each RGB channel over the neighborhood inside the frame.
//
//   Channel  Direction  Contents
//   s_*      in         tdata = red, green, blue; tuser = func (1 = drain)
//   m_*      out        tdata = red, green, blue; tlast = frame end
//   cfg_*    in         index 0 = frame width, index 1 = frame height
//
// One beat per clock in and out unless the output stalls; a beat passes s1,
// s2 and s3 to the output register; results lag the input by width+1 beats.
// All stages advance together whenever the output register is free or taken.
// Reset clears control state and sets width 640, height 480; the line
// buffers are not cleared, and unwritten entries only feed masked rows.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_core
    import bb3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // in_red, in_green, in_blue
    input  logic [0:0]            s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // out_red, out_green, out_blue
    output logic                  m_tlast,   // frame_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [EW_W-1:0] eff_w;
    logic [FH_W-1:0] eff_h;

    col_addr_t       in_col_reg,  in_col_next;
    logic [IR_W-1:0] in_row_reg,  in_row_next;
    col_addr_t       out_col_reg, out_col_next;
    logic [FH_W-1:0] out_row_reg, out_row_next;

    logic      adv;
    logic      accept;
    logic      cfg_write;
    logic      pixel_phase;
    logic      take;
    logic      emit;
    logic      last;
    pixel_t    pix;
    win_mask_t mask;

    logic      s1_valid_reg;
    logic      s1_emit_reg;
    col_addr_t s1_col_reg;
    pixel_t    s1_pix_reg;
    win_mask_t s1_mask_reg;
    logic      s1_last_reg;

    logic      s2_valid_reg;
    win_mask_t s2_mask_reg;
    logic      s2_last_reg;

    logic             s3_valid_reg;
    logic [SUM_W-1:0] s3_red_reg;
    logic [SUM_W-1:0] s3_green_reg;
    logic [SUM_W-1:0] s3_blue_reg;
    div_kind_t        s3_kind_reg;
    logic             s3_last_reg;

    logic   out_valid_reg;
    pixel_t out_pix_reg;
    logic   out_last_reg;

    line_pair_t rd_data;
    line_pair_t wr_data;
    logic       shift;
    win_col_t   new_col;
    win_col_t   col_l, col_c, col_r;
    cell_mask_t mask_l, mask_c, mask_r;
    chan_sum_t  sum_l, sum_c, sum_r;
    logic [SUM_W-1:0] tot_red, tot_green, tot_blue;
    div_kind_t  kind;
    pixel_t     mean_pix;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg_write = cfg_valid && cfg_ready;

    // Effective frame size: width clamped to 2..MAX_WIDTH, height to at least 2.
    always_comb
    begin
        priority if (frame_width_reg < FW_W'(2))
        begin
            eff_w = EW_W'(2);
        end
        else if (EW_W'(frame_width_reg) > EW_W'(MAX_WIDTH))
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(frame_width_reg);
        end
        eff_h = (frame_height_reg < FH_W'(2)) ? FH_W'(2) : frame_height_reg;
    end

    // Input side: position bookkeeping and the window masks of the result
    // this beat completes.
    always_comb
    begin
        logic [EW_W-1:0] in_col_inc;
        logic [EW_W-1:0] out_col_inc;
        logic [FH_W:0]   out_row_inc;
        in_col_inc  = EW_W'(in_col_reg) + EW_W'(1);
        out_col_inc = EW_W'(out_col_reg) + EW_W'(1);
        out_row_inc = {1'b0, out_row_reg} + (FH_W + 1)'(1);

        pixel_phase = in_row_reg < IR_W'(eff_h);
        take        = accept && !(s_tuser[0] && pixel_phase);
        pix         = pixel_phase ? pixel_t'(s_tdata) : '0;
        emit        = (in_row_reg >= IR_W'(2))
                   || (in_row_reg == IR_W'(1) && in_col_reg != '0);

        mask.top   = out_row_reg != '0;
        mask.bot   = out_row_inc < (FH_W + 1)'(eff_h);
        mask.left  = out_col_reg != '0;
        mask.right = out_col_inc < eff_w;
        last       = !mask.bot && !mask.right;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (take)
        begin
            if (in_col_inc >= eff_w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IR_W'(1);
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_inc >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[FH_W-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
        if (cfg_write)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_W'(640);
            frame_height_reg <= FH_W'(480);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    default:          ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= take;
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_emit_reg  <= emit;
            s1_col_reg   <= in_col_reg;
            s1_pix_reg   <= pix;
            s1_mask_reg  <= mask;
            s1_last_reg  <= last;
            s2_mask_reg  <= s1_mask_reg;
            s2_last_reg  <= s1_last_reg;
            s3_red_reg   <= tot_red;
            s3_green_reg <= tot_green;
            s3_blue_reg  <= tot_blue;
            s3_kind_reg  <= kind;
            s3_last_reg  <= s2_last_reg;
            out_pix_reg  <= mean_pix;
            out_last_reg <= s3_last_reg;
        end
    end

    // The line buffers move down one row: the old middle entry becomes the
    // upper one and the new pixel takes the middle.
    assign wr_data.mid = s1_pix_reg;
    assign wr_data.up  = rd_data.mid;

    bb3_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (rd_data),
        .wr_en   (adv && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    assign shift       = adv && s1_valid_reg;
    assign new_col.top = rd_data.up;
    assign new_col.mid = rd_data.mid;
    assign new_col.bot = s1_pix_reg;

    assign mask_r = '{use_col: s2_mask_reg.right, use_top: s2_mask_reg.top,
                      use_bot: s2_mask_reg.bot};
    assign mask_c = '{use_col: 1'b1, use_top: s2_mask_reg.top,
                      use_bot: s2_mask_reg.bot};
    assign mask_l = '{use_col: s2_mask_reg.left, use_top: s2_mask_reg.top,
                      use_bot: s2_mask_reg.bot};

    bb3_cell u_cell_r (
        .clk     (clk),
        .shift   (shift),
        .col_in  (new_col),
        .col_out (col_r),
        .mask    (mask_r),
        .col_sum (sum_r)
    );

    bb3_cell u_cell_c (
        .clk     (clk),
        .shift   (shift),
        .col_in  (col_r),
        .col_out (col_c),
        .mask    (mask_c),
        .col_sum (sum_c)
    );

    bb3_cell u_cell_l (
        .clk     (clk),
        .shift   (shift),
        .col_in  (col_c),
        .col_out (col_l),
        .mask    (mask_l),
        .col_sum (sum_l)
    );

    always_comb
    begin
        tot_red   = SUM_W'(sum_l.red)   + SUM_W'(sum_c.red)   + SUM_W'(sum_r.red);
        tot_green = SUM_W'(sum_l.green) + SUM_W'(sum_c.green) + SUM_W'(sum_r.green);
        tot_blue  = SUM_W'(sum_l.blue)  + SUM_W'(sum_c.blue)  + SUM_W'(sum_r.blue);
        priority if (s2_mask_reg.top && s2_mask_reg.bot
                     && s2_mask_reg.left && s2_mask_reg.right)
        begin
            kind = DIV_NINE;
        end
        else if ((s2_mask_reg.top && s2_mask_reg.bot)
                 || (s2_mask_reg.left && s2_mask_reg.right))
        begin
            kind = DIV_SIX;
        end
        else
        begin
            kind = DIV_FOUR;
        end
    end

    bb3_mean u_mean_red (
        .sum  (s3_red_reg),
        .kind (s3_kind_reg),
        .mean (mean_pix.red)
    );

    bb3_mean u_mean_green (
        .sum  (s3_green_reg),
        .kind (s3_kind_reg),
        .mean (mean_pix.green)
    );

    bb3_mean u_mean_blue (
        .sum  (s3_blue_reg),
        .kind (s3_kind_reg),
        .mean (mean_pix.blue)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    // The left cell's column leaves the window here.
    logic unused_col;
    assign unused_col = ^col_l;

endmodule

// ----- design/bb3_line_mem.sv -----
// ----------------------------------------------------------------------------
// bb3_line_mem: line buffer pair
// One entry per column holds the pixels one and two rows above; registered read.
// ----------------------------------------------------------------------------
module bb3_line_mem
    import bb3_pkg::*;
(
    input  logic       clk,
    input  logic       rd_en,
    input  col_addr_t  rd_addr,
    output line_pair_t rd_data,
    input  logic       wr_en,
    input  col_addr_t  wr_addr,
    input  line_pair_t wr_data
);

    line_pair_t mem [MAX_WIDTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/bb3_cell.sv -----
// ----------------------------------------------------------------------------
// bb3_cell: one column of the 3x3 window
// Holds three pixels, passes them to its left neighbor on each shift and
// gives the per-channel sum of the rows that lie inside the frame.
// ----------------------------------------------------------------------------
module bb3_cell
    import bb3_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  win_col_t   col_in,
    output win_col_t   col_out,
    input  cell_mask_t mask,
    output chan_sum_t  col_sum
);

    win_col_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    always_comb
    begin
        pixel_t p_top;
        pixel_t p_bot;
        p_top = mask.use_top ? col_reg.top : '0;
        p_bot = mask.use_bot ? col_reg.bot : '0;
        col_sum.red   = CSUM_W'(p_top.red)   + CSUM_W'(col_reg.mid.red)   + CSUM_W'(p_bot.red);
        col_sum.green = CSUM_W'(p_top.green) + CSUM_W'(col_reg.mid.green) + CSUM_W'(p_bot.green);
        col_sum.blue  = CSUM_W'(p_top.blue)  + CSUM_W'(col_reg.mid.blue)  + CSUM_W'(p_bot.blue);
        if (!mask.use_col)
        begin
            col_sum = '0;
        end
    end

endmodule

// ----- design/bb3_mean.sv -----
// ----------------------------------------------------------------------------
// bb3_mean: rounded mean of one channel
// Computes (2*sum + n) / (2*n) for n = 4, 6 or 9 with reciprocal multiplies.
// ----------------------------------------------------------------------------
module bb3_mean
    import bb3_pkg::*;
(
    input  logic [SUM_W-1:0] sum,
    input  div_kind_t        kind,
    output logic [7:0]       mean
);

    logic [SUM_W-1:0] x4;
    logic [SUM_W-1:0] x6;
    logic [SUM_W:0]   y9;
    logic [23:0]      p6;
    logic [25:0]      p9;

    // Over the reachable sums the reciprocal error stays below the gap to
    // the next integer, so truncating the product gives the exact quotient.
    always_comb
    begin
        x4 = sum + SUM_W'(2);
        x6 = sum + SUM_W'(3);
        y9 = {sum, 1'b0} + (SUM_W + 1)'(9);
        p6 = 24'(x6) * 24'(2731);
        p9 = 26'(y9) * 26'(3641);
        unique case (kind)
            DIV_FOUR: mean = x4[9:2];
            DIV_SIX:  mean = p6[21:14];
            DIV_NINE: mean = p9[23:16];
            default:  mean = '0;
        endcase
    end

endmodule

// ----- sim/box_blur_3x3_edge_clipped_core_test.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_core_test: regression bench of the 3x3 box blur
// Streams RGB frames of random and extreme sizes through the core, predicts
// every blurred pixel with a line-buffer model of its own and compares each
// output beat field by field, with random stalls on both sides and a long hold.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_core_test;
    import bb3_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int SETTLE       = 8;
    localparam int QUIET_LIMIT  = 3000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        pixel_t px;
        bit     last;
    } blurred_t;

    class box_blur_checker;
        int unsigned width_reg;
        int unsigned height_reg;
        pixel_t      upper_row [MAX_WIDTH];
        pixel_t      middle_row [MAX_WIDTH];
        win_col_t    window [3];
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_col;
        int unsigned out_row;
        blurred_t    expected_pixels [$];
        int unsigned mismatch_count;

        function new();
            width_reg = 640;
            height_reg = 480;
            mismatch_count = 0;
            frame_restart();
        endfunction

        function void frame_restart();
            foreach (window[i])
                window[i] = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int unsigned used_width();
            if (width_reg < 2)
                return 2;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned used_height();
            return (height_reg < 2) ? 2 : height_reg;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = val & 16'h07FF;
            else
                height_reg = val;
            frame_restart();
        endfunction

        // Advances the line buffers and the window by one accepted beat and
        // queues the blurred pixel that the beat completes, if any.
        function void take_pixel(bit drain, pixel_t px);
            int unsigned w;
            int unsigned h;
            int unsigned col;
            int unsigned n;
            int unsigned sum_r;
            int unsigned sum_g;
            int unsigned sum_b;
            bit          in_frame;
            bit          emit;
            bit [2:0]    use_row;
            bit [2:0]    use_col;
            pixel_t      pin;
            pixel_t      up;
            pixel_t      mid;
            pixel_t      cellp;
            blurred_t    res;

            w = used_width();
            h = used_height();
            in_frame = in_row < h;
            if (drain && in_frame)
                return;
            pin = in_frame ? px : '0;
            col = in_col % MAX_WIDTH;
            up = upper_row[col];
            mid = middle_row[col];
            upper_row[col] = mid;
            middle_row[col] = pin;
            window[0] = window[1];
            window[1] = window[2];
            window[2].top = up;
            window[2].mid = mid;
            window[2].bot = pin;

            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (!emit)
                return;

            use_row = {out_row + 1 < h, 1'b1, out_row > 0};
            use_col = {out_col + 1 < w, 1'b1, out_col > 0};
            n = 0;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int ci = 0; ci < 3; ci++)
            begin
                for (int ri = 0; ri < 3; ri++)
                begin
                    if (use_col[ci] && use_row[ri])
                    begin
                        case (ri)
                            0:       cellp = window[ci].top;
                            1:       cellp = window[ci].mid;
                            default: cellp = window[ci].bot;
                        endcase
                        sum_r += cellp.red;
                        sum_g += cellp.green;
                        sum_b += cellp.blue;
                        n++;
                    end
                end
            end
            // Exact half-up rounding of sum / n.
            res.px.red   = 8'((2 * sum_r + n) / (2 * n));
            res.px.green = 8'((2 * sum_g + n) / (2 * n));
            res.px.blue  = 8'((2 * sum_b + n) / (2 * n));
            res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_pixels.push_back(res);

            if (res.last)
                frame_restart();
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_blurred(pixel_t got, bit got_last);
            blurred_t want;

            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected blurred beat: rgb %h %h %h last %b",
                             got.red, got.green, got.blue, got_last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red !== want.px.red || got.green !== want.px.green
                || got.blue !== want.px.blue || got_last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("blurred beat mismatch: expected rgb %h %h %h last %b, got %h %h %h last %b",
                             want.px.red, want.px.green, want.px.blue, want.last,
                             got.red, got.green, got.blue, got_last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    pixel_t                s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    pixel_t                m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    box_blur_checker blur_check;
    int              src_idle_pct;
    int              sink_idle_pct;
    int              sink_hold;
    int              quiet_cycles;

    box_blur_3x3_edge_clipped_core DUT (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Output side: random backpressure, or a long hold when one is requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                blur_check.check_blurred(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                blur_check.take_pixel(s_tuser[0], s_tdata);
            if (cfg_valid && cfg_ready)
                blur_check.set_register(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("box_blur_3x3_edge_clipped_core regression: fail");
            $finish;
        end
    end

    function automatic pixel_t random_pixel();
        return pixel_t'(24'($urandom()));
    endfunction

    // The idle mix follows the share of the random beats already sent.
    function automatic void pick_idle_mix(int sent);
        if (sent < RANDOM_ITEMS / 3)
        begin
            src_idle_pct = 12;
            sink_idle_pct = 70;
        end
        else if (sent < 2 * RANDOM_ITEMS / 3)
        begin
            src_idle_pct = 70;
            sink_idle_pct = 12;
        end
        else
        begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
        end
    endfunction

    task automatic send_beat(input bit drain, input pixel_t px);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        s_tuser <= drain;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering beats until every predicted pixel is out, then lets the
    // pipeline settle so that beats without a result have left it as well.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (blur_check.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int          items_sent;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned total;
        int unsigned cut;
        bit          big_done;
        bit          stall_done;
        bit          prev_complete;
        bit          big_run;
        logic [CFG_DATA_W-1:0] width_raw;
        logic [CFG_DATA_W-1:0] height_raw;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        sink_hold = 0;
        quiet_cycles = 0;
        src_idle_pct = 12;
        sink_idle_pct = 70;
        blur_check = new();
        items_sent = 0;
        big_done = 1'b0;
        stall_done = 1'b0;
        prev_complete = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Smallest frame, both sizes clamped up to 2: corners only, a drain
        // beat inside the frame, and a pixel beat that serves as a drain.
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'h123456);
        send_beat(1'b0, 24'h000000);
        send_beat(1'b0, 24'h010101);
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'h000000);
        send_beat(1'b0, 24'hA5A5A5);
        send_beat(1'b1, 24'hFFFFFF);
        send_beat(1'b1, 24'h000000);
        wait_idle();

        // 3x3 frame covers corner, edge and interior windows; the width write
        // carries junk in the bits above the register.
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        write_reg(CFG_FRAME_WIDTH, 16'hF803);
        for (int i = 0; i < 9; i++)
            send_beat(1'b0, {8'(i * 31), 8'(255 - i * 29), i[0] ? 8'hFF : 8'h00});
        for (int i = 0; i <= 3; i++)
            send_beat(1'b1, 24'h000000);

        while (items_sent < RANDOM_ITEMS)
        begin
            pick_idle_mix(items_sent);

            big_run = 1'b0;
            // Most frames start after a full drain and a new setting; some
            // follow the previous frame back to back.
            if (!prev_complete || $urandom_range(0, 9) < 7)
            begin
                wait_idle();
                if (!big_done && items_sent >= 450)
                begin
                    // Width far beyond the line buffers, clamped to their depth.
                    width_raw = 16'hFFFF;
                    height_raw = 16'd2;
                    big_done = 1'b1;
                    big_run = 1'b1;
                end
                else
                begin
                    width_raw = {5'($urandom()), 11'($urandom_range(0, 10))};
                    if ($urandom_range(0, 9) == 0)
                        height_raw = 16'($urandom_range(16'h8000, 16'hFFFF));
                    else
                        height_raw = 16'($urandom_range(0, 6));
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    write_reg(CFG_FRAME_WIDTH, width_raw);
                    write_reg(CFG_FRAME_HEIGHT, height_raw);
                end
                else
                begin
                    write_reg(CFG_FRAME_HEIGHT, height_raw);
                    write_reg(CFG_FRAME_WIDTH, width_raw);
                end
            end

            w_eff = blur_check.used_width();
            h_eff = blur_check.used_height();
            total = w_eff * h_eff;
            if (big_run)
                cut = MAX_WIDTH + 24;
            else if (h_eff > 16)
                cut = $urandom_range(2 * w_eff, 6 * w_eff);
            else if ($urandom_range(0, 9) == 0)
                cut = $urandom_range(1, total - 1);
            else
                cut = total;

            for (int unsigned i = 0; i < cut; i++)
            begin
                pick_idle_mix(items_sent);
                if (!stall_done && sink_idle_pct == 0 && items_sent >= 1300)
                begin
                    // Hold the output long enough for the core to back up.
                    sink_hold = 300;
                    stall_done = 1'b1;
                end
                if ($urandom_range(0, 99) < 4)
                begin
                    send_beat(1'b1, random_pixel());
                    items_sent++;
                end
                send_beat(1'b0, random_pixel());
                items_sent++;
            end

            prev_complete = (cut == total);
            if (prev_complete)
            begin
                for (int unsigned i = 0; i <= w_eff; i++)
                begin
                    send_beat($urandom_range(0, 4) != 0, random_pixel());
                    items_sent++;
                end
                repeat ($urandom_range(0, 2)) send_beat(1'b1, random_pixel());
            end
        end

        wait_idle();
        if (blur_check.mismatch_count == 0 && blur_check.pending() == 0)
            $display("box_blur_3x3_edge_clipped_core regression: pass");
        else
            $display("box_blur_3x3_edge_clipped_core regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bb3_pkg.sv
design/bb3_line_mem.sv
design/bb3_cell.sv
design/bb3_mean.sv
design/box_blur_3x3_edge_clipped_core.sv
sim/box_blur_3x3_edge_clipped_core_test.sv
